[sv/msrg_pkg.sv]
// Shared types and constants of the multi-servo ramp generator.
// No dependencies; imported by msrg_out, the top level and the bench.
package msrg_pkg;

  localparam int CHANNELS_DEF = 16;
  localparam int TICK_MS_DEF  = 10;

  localparam int ANGLE_W = 16;
  localparam int STEP_W  = 17;
  localparam int DUR_W   = 16;
  localparam int VEL_W   = 24;
  localparam int THR_W   = 8;
  localparam int CHOUT_W = 4;
  localparam int PWM_W   = 12;

  localparam logic [ANGLE_W-1:0] ANGLE_MAX = 16'd46080;
  localparam logic [THR_W-1:0]   THR_RESET = 8'd26;
  // velocity is per second, step is per tick in ms
  localparam logic [DUR_W-1:0]   VEL_DEN   = 16'd1000;

  // velocity*TICK_MS (TICK_MS up to 1000); from 65536*1000 up the step saturates,
  // below that a reciprocal multiply by 1/1000 is exact
  localparam int                 VNUM_W    = VEL_W + 10;
  localparam int                 VQ_W      = 26;
  localparam logic [VNUM_W-1:0]  VEL_SAT   = VNUM_W'(65536000);
  localparam logic [26:0]        VEL_RCP   = 27'd68719477;
  localparam int                 VEL_SHIFT = 36;

  // pwm = (2*angle + 23040) / 225, done as a reciprocal multiply (exact here)
  localparam logic [17:0] PWM_OFS   = 18'd23040;
  localparam logic [17:0] PWM_MUL   = 18'd149131;
  localparam int          PWM_SHIFT = 25;

  typedef struct packed {
    logic [ANGLE_W-1:0]       cur;
    logic [ANGLE_W-1:0]       goal;
    logic signed [STEP_W-1:0] step;
  } chan_rec_t;

  typedef struct packed {
    logic               pwm_valid;
    logic [CHOUT_W-1:0] chn;
    logic [ANGLE_W-1:0] angle;
    logic               last;
    logic               all_done;
  } res_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SET_RD,
    ST_SET_CALC,
    ST_SET_DIV,
    ST_SET_WR,
    ST_PASS1,
    ST_PASS2
  } state_e;

endpackage

[sv/msrg_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module msrg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/msrg_div.sv]
// Restoring divider, one quotient bit per cycle.
// No package dependencies; used by the top level for step sizes.
module msrg_div #(
  parameter int NUM_W = 34,
  parameter int DEN_W = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             run_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] acc_q;
  logic [DEN_W-1:0] rem_q, den_q;
  logic [DEN_W:0]   shifted, sub;
  logic             ge;

  assign shifted = {rem_q, acc_q[NUM_W-1]};
  assign ge      = shifted >= {1'b0, den_q};
  assign sub     = shifted - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(NUM_W);
    end else if (run_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // acc holds the dividend, quotient bits shift in from the bottom
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (run_q) begin
      rem_q <= ge ? sub[DEN_W-1:0] : shifted[DEN_W-1:0];
      acc_q <= {acc_q[NUM_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = acc_q;

endmodule

[sv/msrg_out.sv]
// Result register stage: angle to PWM count conversion and the result strobe.
// Depends on msrg_pkg (res_req_t, PWM constants).
module msrg_out
  import msrg_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  input  res_req_t           req_i,
  output logic               result_stb_o,
  output logic [CHOUT_W-1:0] out_channel_o,
  output logic [PWM_W-1:0]   pwm_count_o,
  output logic               pwm_valid_o,
  output logic               last_of_tick_o,
  output logic               all_done_o
);

  logic [17:0]      pwm_x;
  logic [35:0]      pwm_prod;
  logic [PWM_W-1:0] pwm;

  logic               stb_q;
  logic [CHOUT_W-1:0] chn_q;
  logic [PWM_W-1:0]   pwm_q;
  logic               pv_q, last_q, all_q;

  assign pwm_x    = {1'b0, req_i.angle, 1'b0} + PWM_OFS;
  assign pwm_prod = 36'(pwm_x) * 36'(PWM_MUL);
  assign pwm      = req_i.pwm_valid ? PWM_W'(pwm_prod >> PWM_SHIFT) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stb_q <= 1'b0;
    end else begin
      stb_q <= req_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_i) begin
      chn_q  <= req_i.chn;
      pwm_q  <= pwm;
      pv_q   <= req_i.pwm_valid;
      last_q <= req_i.last;
      all_q  <= req_i.all_done;
    end
  end

  assign result_stb_o   = stb_q;
  assign out_channel_o  = chn_q;
  assign pwm_count_o    = pwm_q;
  assign pwm_valid_o    = pv_q;
  assign last_of_tick_o = last_q;
  assign all_done_o     = all_q;

endmodule

[sv/multi_servo_ramp_generator_unit.sv]
// Multi-servo ramp generator, top level. Depends on msrg_pkg, msrg_ram, msrg_div, msrg_out.
// Set-target: busy through ST_SET_RD, ST_SET_CALC and ST_SET_WR; a same-time move of
//   TICK_MS ms or more adds the serial divide in ST_SET_DIV. Velocity moves use a reciprocal.
// Tick with A active channels: two passes over the channel RAM, one read per cycle;
//   pass 2 gives the results, one per cycle, and busy holds until the last is sent.
//   An idle tick gives a single result with pwm_valid low. Results cannot stall.
// Reset: all channels idle at 0 degrees, threshold 26; no clearing pass (written bits).
module multi_servo_ramp_generator_unit
  import msrg_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF,
  parameter int TICK_MS  = TICK_MS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_we_i,
  input  logic [THR_W-1:0]   cfg_wdata_i,
  input  logic               kind_i,
  input  logic [3:0]         channel_i,
  input  logic [ANGLE_W-1:0] target_angle_i,
  input  logic               move_mode_i,
  input  logic [DUR_W-1:0]   duration_ms_i,
  input  logic [VEL_W-1:0]   velocity_i,
  output logic               result_stb_o,
  output logic [CHOUT_W-1:0] out_channel_o,
  output logic [PWM_W-1:0]   pwm_count_o,
  output logic               pwm_valid_o,
  output logic               last_of_tick_o,
  output logic               all_done_o
);

  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int NUM_W = ANGLE_W + $clog2(TICK_MS + 1);
  localparam int REC_W = $bits(chan_rec_t);

  state_e st_q, st_d;
  logic [THR_W-1:0] thr_q;
  logic [CHANNELS-1:0] active_q, active_d, init_q, init_d;
  logic [CHANNELS-1:0] scan_q, scan_d, run_q, run_d;

  // latched set-target request
  logic [CH_W-1:0]    chn_q, chn_d;
  logic [ANGLE_W-1:0] tgt_q, tgt_d;
  logic               mode_q, mode_d;
  logic [DUR_W-1:0]   dur_q, dur_d;
  logic [VEL_W-1:0]   vel_q, vel_d;
  logic [ANGLE_W-1:0] cur_q, cur_d, dmag_q, dmag_d;
  logic               pos_q, pos_d, neg_q, neg_d;

  // velocity step: product, then reciprocal divide
  logic [VNUM_W-1:0]  vnum;
  logic               vsat_q, vsat_d;
  logic [VQ_W-1:0]    vlo_q, vlo_d;
  logic [VQ_W+26:0]   vprod;
  logic [ANGLE_W-1:0] vmag_q, vmag_d;

  // read return tag
  logic            rv_q, rv_d, rp2_q, rp2_d, rlast_q, rlast_d;
  logic [CH_W-1:0] rch_q, rch_d;

  logic     sv_q, sv_d;
  res_req_t sres_q, sres_d;

  logic             ram_we;
  logic [CH_W-1:0]  ram_waddr, ram_raddr;
  chan_rec_t        ram_wdata, rec_rd;
  logic [REC_W-1:0] ram_rdata;

  logic             div_start, div_done;
  logic [NUM_W-1:0] div_num, div_quot;
  logic [DUR_W-1:0] div_den;

  logic [CH_W-1:0]     low_idx;
  logic [CHANNELS-1:0] scan_clr;

  logic [ANGLE_W-1:0]        rd_cur;
  logic signed [ANGLE_W:0]   set_diff;
  logic [ANGLE_W:0]          set_abs;
  logic                      short_mv;
  logic [ANGLE_W-1:0]        quot_sat, mag;
  logic signed [STEP_W-1:0]  step_w;

  logic signed [ANGLE_W:0]   rem;
  logic [ANGLE_W:0]          remag;
  logic                      retire;
  logic signed [ANGLE_W+1:0] nsum, ngoal, nclamp;
  logic [ANGLE_W-1:0]        nxt;

  msrg_ram #(
    .WIDTH(REC_W),
    .DEPTH(CHANNELS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  msrg_div #(
    .NUM_W(NUM_W),
    .DEN_W(DUR_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  msrg_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (sv_q),
    .req_i         (sres_q),
    .result_stb_o  (result_stb_o),
    .out_channel_o (out_channel_o),
    .pwm_count_o   (pwm_count_o),
    .pwm_valid_o   (pwm_valid_o),
    .last_of_tick_o(last_of_tick_o),
    .all_done_o    (all_done_o)
  );

  assign rec_rd = chan_rec_t'(ram_rdata);
  assign busy   = (st_q != ST_IDLE) || rv_q || sv_q;

  // lowest pending channel of the current pass
  always_comb begin
    low_idx = '0;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      if (scan_q[i]) begin
        low_idx = CH_W'(i);
      end
    end
    scan_clr          = scan_q;
    scan_clr[low_idx] = 1'b0;
  end

  // set-target arithmetic
  always_comb begin
    rd_cur   = init_q[chn_q] ? rec_rd.cur : '0;
    set_diff = $signed({1'b0, tgt_q}) - $signed({1'b0, rd_cur});
    set_abs  = set_diff[ANGLE_W] ? (ANGLE_W+1)'(-set_diff) : (ANGLE_W+1)'(set_diff);
    short_mv = !mode_q && (dur_q < DUR_W'(TICK_MS));
    vnum     = VNUM_W'(vel_q) * VNUM_W'(TICK_MS);
    vprod    = (VQ_W+27)'(vlo_q) * (VQ_W+27)'(VEL_RCP);
    div_num  = NUM_W'(dmag_q) * NUM_W'(TICK_MS);
    div_den  = dur_q;
    quot_sat = (|div_quot[NUM_W-1:ANGLE_W]) ? '1 : div_quot[ANGLE_W-1:0];
    mag      = short_mv ? dmag_q : (mode_q ? vmag_q : quot_sat);
    // a move that rounds to no step still creeps one unit
    if (mag == '0 && dmag_q != '0) begin
      mag = ANGLE_W'(1);
    end
    if (pos_q) begin
      step_w = $signed({1'b0, mag});
    end else if (neg_q) begin
      step_w = -$signed({1'b0, mag});
    end else begin
      step_w = '0;
    end
  end

  // tick arithmetic on the returned record
  always_comb begin
    rem    = $signed({1'b0, rec_rd.goal}) - $signed({1'b0, rec_rd.cur});
    remag  = rem[ANGLE_W] ? (ANGLE_W+1)'(-rem) : (ANGLE_W+1)'(rem);
    retire = remag <= (ANGLE_W+1)'(thr_q);
    nsum   = $signed({2'b00, rec_rd.cur}) + $signed({rec_rd.step[STEP_W-1], rec_rd.step});
    ngoal  = $signed({2'b00, rec_rd.goal});
    nclamp = nsum;
    if (!rec_rd.step[STEP_W-1] && rec_rd.step != '0 && nsum > ngoal) begin
      nclamp = ngoal;
    end
    if (rec_rd.step[STEP_W-1] && nsum < ngoal) begin
      nclamp = ngoal;
    end
    if (nclamp[ANGLE_W+1]) begin
      nclamp = '0;
    end
    if (nclamp > $signed({2'b00, ANGLE_MAX})) begin
      nclamp = $signed({2'b00, ANGLE_MAX});
    end
    nxt = nclamp[ANGLE_W-1:0];
  end

  always_comb begin
    st_d      = st_q;
    active_d  = active_q;
    init_d    = init_q;
    scan_d    = scan_q;
    run_d     = run_q;
    chn_d     = chn_q;
    tgt_d     = tgt_q;
    mode_d    = mode_q;
    dur_d     = dur_q;
    vel_d     = vel_q;
    cur_d     = cur_q;
    dmag_d    = dmag_q;
    pos_d     = pos_q;
    neg_d     = neg_q;
    vsat_d    = vsat_q;
    vlo_d     = vlo_q;
    vmag_d    = vmag_q;
    rv_d      = 1'b0;
    rp2_d     = rp2_q;
    rlast_d   = rlast_q;
    rch_d     = rch_q;
    sv_d      = 1'b0;
    sres_d    = sres_q;
    ram_we    = 1'b0;
    ram_waddr = rch_q;
    ram_wdata = '{cur: nxt, goal: rec_rd.goal, step: rec_rd.step};
    ram_raddr = low_idx;
    div_start = 1'b0;

    // returning read: pass 1 decides retirement, pass 2 moves and reports
    if (rv_q) begin
      if (!rp2_q) begin
        if (retire) begin
          active_d[rch_q] = 1'b0;
        end
      end else begin
        ram_we = 1'b1;
        sv_d   = 1'b1;
        sres_d = '{pwm_valid: 1'b1, chn: CHOUT_W'(rch_q), angle: nxt,
                   last: rlast_q, all_done: (active_q == '0)};
      end
    end

    case (st_q)
      ST_IDLE: begin
        if (start && !busy) begin
          if (!kind_i) begin
            if (int'(channel_i) < CHANNELS) begin
              chn_d     = CH_W'(channel_i);
              tgt_d     = (target_angle_i > ANGLE_MAX) ? ANGLE_MAX : target_angle_i;
              mode_d    = move_mode_i;
              dur_d     = duration_ms_i;
              vel_d     = velocity_i;
              ram_raddr = CH_W'(channel_i);
              st_d      = ST_SET_RD;
            end
          end else if (active_q == '0) begin
            sv_d   = 1'b1;
            sres_d = '{pwm_valid: 1'b0, chn: '0, angle: '0, last: 1'b1, all_done: 1'b1};
          end else begin
            scan_d = active_q;
            run_d  = active_q;
            st_d   = ST_PASS1;
          end
        end
      end
      ST_SET_RD: begin
        cur_d  = rd_cur;
        dmag_d = set_abs[ANGLE_W-1:0];
        pos_d  = !set_diff[ANGLE_W] && (set_diff != '0);
        neg_d  = set_diff[ANGLE_W];
        vsat_d = (vnum >= VEL_SAT);
        vlo_d  = vnum[VQ_W-1:0];
        st_d   = ST_SET_CALC;
      end
      ST_SET_CALC: begin
        vmag_d = vsat_q ? '1 : vprod[VEL_SHIFT +: ANGLE_W];
        if (short_mv || mode_q) begin
          st_d = ST_SET_WR;
        end else begin
          div_start = 1'b1;
          st_d      = ST_SET_DIV;
        end
      end
      ST_SET_DIV: begin
        if (div_done) begin
          st_d = ST_SET_WR;
        end
      end
      ST_SET_WR: begin
        ram_we          = 1'b1;
        ram_waddr       = chn_q;
        ram_wdata       = '{cur: cur_q, goal: tgt_q, step: step_w};
        active_d[chn_q] = 1'b1;
        init_d[chn_q]   = 1'b1;
        st_d            = ST_IDLE;
      end
      ST_PASS1: begin
        if (scan_q != '0) begin
          rv_d   = 1'b1;
          rp2_d  = 1'b0;
          rch_d  = low_idx;
          scan_d = scan_clr;
        end else begin
          scan_d = run_q;
          st_d   = ST_PASS2;
        end
      end
      ST_PASS2: begin
        if (scan_q != '0) begin
          rv_d    = 1'b1;
          rp2_d   = 1'b1;
          rch_d   = low_idx;
          rlast_d = (scan_clr == '0);
          scan_d  = scan_clr;
        end else begin
          st_d = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      thr_q    <= THR_RESET;
      active_q <= '0;
      init_q   <= '0;
      scan_q   <= '0;
      run_q    <= '0;
      rv_q     <= 1'b0;
      sv_q     <= 1'b0;
    end else begin
      st_q     <= st_d;
      active_q <= active_d;
      init_q   <= init_d;
      scan_q   <= scan_d;
      run_q    <= run_d;
      rv_q     <= rv_d;
      sv_q     <= sv_d;
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    chn_q   <= chn_d;
    tgt_q   <= tgt_d;
    mode_q  <= mode_d;
    dur_q   <= dur_d;
    vel_q   <= vel_d;
    cur_q   <= cur_d;
    dmag_q  <= dmag_d;
    pos_q   <= pos_d;
    neg_q   <= neg_d;
    vsat_q  <= vsat_d;
    vlo_q   <= vlo_d;
    vmag_q  <= vmag_d;
    rp2_q   <= rp2_d;
    rlast_q <= rlast_d;
    rch_q   <= rch_d;
    sres_q  <= sres_d;
  end

endmodule

[bench/tb_multi_servo_ramp_generator_unit.sv]
// Self-checking bench for the multi-servo ramp generator top level.
// Depends on msrg_pkg and the RTL only; predicts every PWM update and checks it.
module tb_multi_servo_ramp_generator_unit
  import msrg_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_CH          = CHANNELS_DEF;
  localparam int N_DIR         = 25;
  localparam int RAND_PHASES   = 5;
  localparam int PHASE_ITEMS   = 37;
  localparam int SETTLE_CYC    = 48;
  localparam logic [THR_W-1:0] THR_TOP = 8'd255;

  typedef enum logic {CMD_SET = 1'b0, CMD_TICK = 1'b1} cmd_kind_e;
  typedef enum logic {MODE_SAME_TIME = 1'b0, MODE_SAME_VEL = 1'b1} move_mode_e;

  typedef struct packed {
    logic               valid;
    logic [CHOUT_W-1:0] chn;
    logic [PWM_W-1:0]   pwm;
    logic               last_one;
    logic               all_done;
  } pwm_upd_t;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [3:0]         ch;
    logic [ANGLE_W-1:0] tgt;
    move_mode_e         mode;
    logic [DUR_W-1:0]   dur;
    logic [VEL_W-1:0]   vel;
    logic               typed;
    pwm_upd_t           want;
  } stim_row_t;

  localparam pwm_upd_t NO_UPD = '0;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               start          = 1'b0;
  logic               busy;
  logic               cfg_we_i       = 1'b0;
  logic [THR_W-1:0]   cfg_wdata_i    = '0;
  logic               kind_i         = 1'b0;
  logic [3:0]         channel_i      = '0;
  logic [ANGLE_W-1:0] target_angle_i = '0;
  logic               move_mode_i    = 1'b0;
  logic [DUR_W-1:0]   duration_ms_i  = '0;
  logic [VEL_W-1:0]   velocity_i     = '0;
  logic               result_stb_o;
  logic [CHOUT_W-1:0] out_channel_o;
  logic [PWM_W-1:0]   pwm_count_o;
  logic               pwm_valid_o;
  logic               last_of_tick_o;
  logic               all_done_o;

  multi_servo_ramp_generator_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .kind_i         (kind_i),
    .channel_i      (channel_i),
    .target_angle_i (target_angle_i),
    .move_mode_i    (move_mode_i),
    .duration_ms_i  (duration_ms_i),
    .velocity_i     (velocity_i),
    .result_stb_o   (result_stb_o),
    .out_channel_o  (out_channel_o),
    .pwm_count_o    (pwm_count_o),
    .pwm_valid_o    (pwm_valid_o),
    .last_of_tick_o (last_of_tick_o),
    .all_done_o     (all_done_o)
  );

  // Servo state as the bench believes it
  logic [ANGLE_W-1:0] srv_cur    [N_CH];
  logic [ANGLE_W-1:0] srv_goal   [N_CH];
  int                 srv_step   [N_CH];
  logic [N_CH-1:0]    srv_moving;
  logic [THR_W-1:0]   arrive_thr;

  pwm_upd_t pwm_upd_q [$];
  pwm_upd_t want_upd;
  int       err_cnt = 0;

  // Directed requests: extremes, both modes, and each corner of the step math
  stim_row_t dir_tab [N_DIR] = '{
    '{CMD_TICK, 4'd0,  16'd0,     MODE_SAME_TIME, 16'd0,     24'd0,
      1'b1, '{1'b0, 4'd0, 12'd0, 1'b1, 1'b1}},
    '{CMD_SET,  4'd0,  16'd46080, MODE_SAME_TIME, 16'd0,     24'd0,        1'b0, NO_UPD},
    '{CMD_TICK, 4'd0,  16'd0,     MODE_SAME_TIME, 16'd0,     24'd0,
      1'b1, '{1'b1, 4'd0, 12'd512, 1'b1, 1'b0}},
    '{CMD_TICK, 4'd0,  16'd0,     MODE_SAME_TIME, 16'd0,     24'd0,
      1'b1, '{1'b1, 4'd0, 12'd512, 1'b1, 1'b1}},
    '{CMD_SET,  4'd15, 16'hFFFF,  MODE_SAME_VEL,  16'hFFFF,  24'hFFFFFF,   1'b0, NO_UPD},
    '{CMD_TICK, 4'd0,  16'd0,     MODE_SAME_TIME, 16'd0,     24'd0,
      1'b1, '{1'b1, 4'd15, 12'd512, 1'b1, 1'b0}},
    '{CMD_TICK, 4'd0,  16'd0,     MODE_SAME_TIME, 16'd0,     24'd0,
      1'b1, '{1'b1, 4'd15, 12'd512, 1'b1, 1'b1}},
    '{CMD_SET,  4'd0,  16'd0,     MODE_SAME_TIME, 16'd9,     24'd0,        1'b0, NO_UPD},
    '{CMD_TICK, 4'd0,  16'd0,     MODE_SAME_TIME, 16'd0,     24'd0,
      1'b1, '{1'b1, 4'd0, 12'd102, 1'b1, 1'b0}},
    '{CMD_TICK, 4'd0,  16'd0,     MODE_SAME_TIME, 16'd0,     24'd0,
      1'b1, '{1'b1, 4'd0, 12'd102, 1'b1, 1'b1}},
    '{CMD_SET,  4'd1,  16'd1,     MODE_SAME_VEL,  16'd0,     24'd0,        1'b0, NO_UPD},
    '{CMD_SET,  4'd3,  16'd100,   MODE_SAME_TIME, 16'd10,    24'd0,        1'b0, NO_UPD},
    '{CMD_SET,  4'd7,  16'd5000,  MODE_SAME_VEL,  16'd0,     24'd12345,    1'b0, NO_UPD},
    '{CMD_SET,  4'd2,  16'd0,     MODE_SAME_TIME, 16'd100,   24'd0,        1'b0, NO_UPD},
    '{CMD_SET,  4'd15, 16'd0,     MODE_SAME_TIME, 16'd65535, 24'd0,        1'b0, NO_UPD},
    '{CMD_TICK, 4'd0,  16'd0,     MODE_SAME_TIME, 16'd0,     24'd0,        1'b0, NO_UPD},
    '{CMD_TICK, 4'd5,  16'd0,     MODE_SAME_VEL,  16'd0,     24'd0,        1'b0, NO_UPD},
    '{CMD_SET,  4'd8,  16'd46081, MODE_SAME_VEL,  16'd0,     24'd999,      1'b0, NO_UPD},
    '{CMD_SET,  4'd4,  16'd23040, MODE_SAME_TIME, 16'd10000, 24'd0,        1'b0, NO_UPD},
    '{CMD_TICK, 4'd0,  16'd0,     MODE_SAME_TIME, 16'd0,     24'd0,        1'b0, NO_UPD},
    '{CMD_TICK, 4'd0,  16'd0,     MODE_SAME_TIME, 16'd0,     24'd0,        1'b0, NO_UPD},
    '{CMD_SET,  4'd15, 16'd46080, MODE_SAME_VEL,  16'd0,     24'hFFFFFF,   1'b0, NO_UPD},
    '{CMD_TICK, 4'd0,  16'd0,     MODE_SAME_TIME, 16'd0,     24'd0,        1'b0, NO_UPD},
    '{CMD_TICK, 4'd0,  16'd0,     MODE_SAME_TIME, 16'd0,     24'd0,        1'b0, NO_UPD},
    '{CMD_TICK, 4'd0,  16'd0,     MODE_SAME_TIME, 16'd0,     24'd0,        1'b0, NO_UPD}
  };

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH %s", $realtime, msg);
    err_cnt++;
  endtask

  task automatic chk_field(input string fld, input logic [11:0] got, input logic [11:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s: got %0d, want %0d", fld, got, want));
    end
  endtask

  function automatic logic [PWM_W-1:0] pwm_of_angle(input int a);
    return PWM_W'((2 * a + 23040) / 225);
  endfunction

  task automatic servo_reset();
    for (int i = 0; i < N_CH; i++) begin
      srv_cur[i]  = '0;
      srv_goal[i] = '0;
      srv_step[i] = 0;
    end
    srv_moving = '0;
    arrive_thr = THR_RESET;
  endtask

  task automatic predict_set(input stim_row_t r);
    int tgt_sat;
    int diff;
    int dmag;
    int mag;
    tgt_sat = (r.tgt > ANGLE_MAX) ? int'(ANGLE_MAX) : int'(r.tgt);
    diff = tgt_sat - int'(srv_cur[r.ch]);
    dmag = (diff < 0) ? -diff : diff;
    if (r.mode == MODE_SAME_TIME) begin
      mag = (r.dur < TICK_MS_DEF) ? dmag : (dmag * TICK_MS_DEF) / int'(r.dur);
    end else begin
      mag = (int'(r.vel) * TICK_MS_DEF) / int'(VEL_DEN);
      if (mag > 65535) mag = 65535;
    end
    // a step that rounds to nothing still creeps one unit
    if (mag == 0 && dmag != 0) mag = 1;
    srv_step[r.ch]   = (diff > 0) ? mag : ((diff < 0) ? -mag : 0);
    srv_goal[r.ch]   = ANGLE_W'(tgt_sat);
    srv_moving[r.ch] = 1'b1;
  endtask

  task automatic predict_tick();
    pwm_upd_t res [N_CH];
    int       n;
    int       cur;
    int       goal;
    int       rem;
    int       nxt;
    logic     none_left;
    n = 0;
    for (int i = 0; i < N_CH; i++) begin
      if (srv_moving[i]) begin
        cur  = int'(srv_cur[i]);
        goal = int'(srv_goal[i]);
        rem  = goal - cur;
        if (rem < 0) rem = -rem;
        nxt = cur + srv_step[i];
        if (srv_step[i] > 0 && nxt > goal) nxt = goal;
        if (srv_step[i] < 0 && nxt < goal) nxt = goal;
        if (nxt < 0) nxt = 0;
        if (nxt > int'(ANGLE_MAX)) nxt = int'(ANGLE_MAX);
        srv_cur[i] = ANGLE_W'(nxt);
        // distance checked before the step, so it still moves once more
        if (rem <= int'(arrive_thr)) srv_moving[i] = 1'b0;
        res[n] = '{1'b1, CHOUT_W'(i), pwm_of_angle(nxt), 1'b0, 1'b0};
        n++;
      end
    end
    none_left = (srv_moving == '0);
    if (n == 0) begin
      pwm_upd_q.push_back('{1'b0, 4'd0, 12'd0, 1'b1, none_left});
    end else begin
      for (int k = 0; k < n; k++) begin
        res[k].all_done = none_left;
        res[k].last_one = (k == n - 1);
        pwm_upd_q.push_back(res[k]);
      end
    end
  endtask

  // Present one request, hold it until taken, then idle for gap cycles
  task automatic send_req(input stim_row_t r, input int gap);
    kind_i         <= r.kind;
    channel_i      <= r.ch;
    target_angle_i <= r.tgt;
    move_mode_i    <= r.mode;
    duration_ms_i  <= r.dur;
    velocity_i     <= r.vel;
    start          <= 1'b1;
    do @(posedge clk_i); while (busy);
    if (r.kind == CMD_TICK) begin
      predict_tick();
    end else begin
      predict_set(r);
    end
    if (r.typed) begin
      void'(pwm_upd_q.pop_back());
      pwm_upd_q.push_back(r.want);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_and_settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (pwm_upd_q.size() != 0 || busy) @(posedge clk_i);
    // a set request makes no update; busy stays high through its divide
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] v);
    drain_and_settle();
    cfg_wdata_i <= v;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    arrive_thr = v;
    cfg_we_i <= 1'b0;
  endtask

  function automatic stim_row_t rand_row();
    stim_row_t r;
    int        sel;
    r.kind = ($urandom_range(0, 9) < 6) ? CMD_TICK : CMD_SET;
    r.ch   = 4'($urandom_range(0, 15));
    sel    = $urandom_range(0, 19);
    if (sel < 17)       r.tgt = ANGLE_W'($urandom_range(0, 46080));
    else if (sel == 17) r.tgt = (($urandom & 1) != 0) ? ANGLE_MAX : '0;
    else                r.tgt = ANGLE_W'($urandom_range(46081, 65535));
    r.mode = move_mode_e'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0:       r.dur = DUR_W'($urandom_range(0, 15));
      1:       r.dur = DUR_W'($urandom_range(10, 400));
      2:       r.dur = DUR_W'($urandom_range(400, 5000));
      default: r.dur = DUR_W'($urandom);
    endcase
    case ($urandom_range(0, 2))
      0:       r.vel = VEL_W'($urandom_range(0, 300));
      1:       r.vel = VEL_W'($urandom_range(300, 200000));
      default: r.vel = VEL_W'($urandom);
    endcase
    r.typed = 1'b0;
    r.want  = NO_UPD;
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && result_stb_o) begin
      if (pwm_upd_q.size() == 0) begin
        report_mismatch($sformatf("unexpected update: ch %0d pwm %0d",
                                  out_channel_o, pwm_count_o));
      end else begin
        want_upd = pwm_upd_q.pop_front();
        chk_field("pwm_valid", 12'(pwm_valid_o), 12'(want_upd.valid));
        chk_field("out_channel", 12'(out_channel_o), 12'(want_upd.chn));
        chk_field("pwm_count", pwm_count_o, want_upd.pwm);
        chk_field("last_of_tick", 12'(last_of_tick_o), 12'(want_upd.last_one));
        chk_field("all_done", 12'(all_done_o), 12'(want_upd.all_done));
      end
    end
  end

  initial begin
    logic [THR_W-1:0] thr;
    logic             burst;
    servo_reset();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < N_DIR; i++) begin
      send_req(dir_tab[i], (i % 3 == 0) ? 0 : $urandom_range(0, 15));
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0:       thr = '0;
        1:       thr = THR_TOP;
        3:       thr = THR_RESET;
        default: thr = THR_W'($urandom_range(1, 254));
      endcase
      write_threshold(thr);
      burst = (p % 2 == 1);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        send_req(rand_row(), burst ? 0 : $urandom_range(0, 15));
      end
    end

    drain_and_settle();
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
